### hdl/trie_word_counter_defines.svh
// ----------------------------------------------------------------------------
// trie_word_counter assertion macros
// Shared assertion helpers, clocked on i_clk and held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TRIE_WORD_COUNTER_DEFINES_SVH
`define TRIE_WORD_COUNTER_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define TWC_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// condition that must never be seen out of reset
`define TWC_NEVER(lbl, expr, msg) \
    `TWC_CHECK(lbl, !(expr), msg)

`endif

### hdl/twc_pkg.sv
// ----------------------------------------------------------------------------
// twc_pkg
// Types and constants shared by the trie word counter modules.
// ----------------------------------------------------------------------------
package twc_pkg;

    // node pool and alphabet
    localparam int NODE_COUNT    = 4096;
    localparam int ALPHABET_SIZE = 52;
    localparam int NODE_W        = $clog2(NODE_COUNT);
    localparam int CODE_W        = $clog2(ALPHABET_SIZE);
    localparam int ROW_W         = NODE_W * ALPHABET_SIZE;
    localparam int COUNT_W       = 16;
    localparam int LETTER_W      = 8;
    localparam int CMD_W         = 2;
    localparam int STATUS_W      = 2;

    // front queue depth (power of two)
    localparam int QUEUE_DEPTH   = 4;
    localparam int PTR_W         = $clog2(QUEUE_DEPTH);
    localparam int FILL_W        = $clog2(QUEUE_DEPTH + 1);

    // letter ranges
    localparam logic [LETTER_W-1:0] CHAR_LOW_A  = 8'h61;
    localparam logic [LETTER_W-1:0] CHAR_LOW_Z  = 8'h7a;
    localparam logic [LETTER_W-1:0] CHAR_UP_A   = 8'h41;
    localparam logic [LETTER_W-1:0] CHAR_UP_Z   = 8'h5a;
    localparam logic [CODE_W-1:0]   UPPER_BASE  = CODE_W'(26);

    localparam logic [NODE_W-1:0]  NODE_ROOT = '0;
    localparam logic [NODE_W-1:0]  NODE_MAX  = NODE_W'(NODE_COUNT - 1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_NOT_FOUND  = 2'd1,
        ST_POOL_FULL  = 2'd2,
        ST_BAD_LETTER = 2'd3
    } t_status;

    // one node's child links
    typedef logic [ALPHABET_SIZE-1:0][NODE_W-1:0] t_row;

    // classified word, as queued between front and back
    typedef struct packed {
        t_cmd              kind;
        logic [CODE_W-1:0] code;
        logic              bad;
        logic              last;
    } t_op;

    // queue head as seen by the back end
    typedef struct packed {
        logic valid;
        t_op  op;
    } t_q_head;

    typedef enum logic [2:0] {
        BK_INIT,
        BK_IDLE,
        BK_STEP,
        BK_ALLOC,
        BK_CNT
    } t_back_state;

endpackage

### hdl/twc_if.sv
// ----------------------------------------------------------------------------
// twc_in_if / twc_out_if
// Valid/ready channels for incoming letters and outgoing word results.
// ----------------------------------------------------------------------------
interface twc_in_if import twc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [LETTER_W-1:0] letter;
    logic                last;

    modport source (output valid, command, letter, last, input ready);
    modport sink   (input valid, command, letter, last, output ready);
endinterface

interface twc_out_if import twc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [COUNT_W-1:0]  count;
    logic [STATUS_W-1:0] status;

    modport source (output valid, count, status, input ready);
    modport sink   (input valid, count, status, output ready);
endinterface

### hdl/twc_ram.sv
// ----------------------------------------------------------------------------
// twc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module twc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/twc_front.sv
// ----------------------------------------------------------------------------
// twc_front
// Accepts words, maps letters to codes, drops unused commands and queues ops.
// ----------------------------------------------------------------------------
`include "trie_word_counter_defines.svh"

module twc_front import twc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    twc_in_if.sink   i_word,
    input  logic     i_pop,
    output t_q_head  o_head
);

    logic [FILL_W-1:0] r_fill, n_fill;
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    t_op               r_q [QUEUE_DEPTH];
    t_op               w_op;
    logic              w_accept;
    logic              w_push;

    // room left in the queue
    assign i_word.ready = (r_fill != FILL_W'(QUEUE_DEPTH));
    assign w_accept     = i_word.valid && i_word.ready;
    assign w_push       = w_accept && (t_cmd'(i_word.command) != CMD_NONE);

    // letter classification
    always_comb begin
        w_op.kind = t_cmd'(i_word.command);
        w_op.last = i_word.last;
        w_op.bad  = 1'b0;
        w_op.code = '0;
        if (i_word.letter >= CHAR_LOW_A && i_word.letter <= CHAR_LOW_Z) begin
            w_op.code = CODE_W'(i_word.letter - CHAR_LOW_A);
        end else if (i_word.letter >= CHAR_UP_A && i_word.letter <= CHAR_UP_Z) begin
            w_op.code = CODE_W'(i_word.letter - CHAR_UP_A) + UPPER_BASE;
        end else begin
            w_op.bad  = 1'b1;
        end
    end

    // pointers and fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (w_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (w_push && !i_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (!w_push && i_pop) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            r_fill   <= n_fill;
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_op;
        end
    end

    assign o_head.valid = (r_fill != '0);
    assign o_head.op    = r_q[r_rd_ptr];

    `TWC_CHECK(a_fill_range, r_fill <= FILL_W'(QUEUE_DEPTH), "queue fill out of range")
    `TWC_NEVER(a_pop_empty, i_pop && (r_fill == '0), "pop from empty queue")

endmodule

### hdl/twc_back.sv
// ----------------------------------------------------------------------------
// twc_back
// Walks the trie node pool per letter, allocates nodes and keeps word counts.
// ----------------------------------------------------------------------------
`include "trie_word_counter_defines.svh"

module twc_back import twc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_q_head    i_head,
    output logic       o_pop,
    twc_out_if.source  o_result
);

    t_back_state        r_state, n_state;
    t_op                r_op, n_op;
    logic [NODE_W-1:0]  r_cur, n_cur;
    logic [NODE_W-1:0]  r_nodes_used, n_nodes_used;
    logic [NODE_W-1:0]  r_new, n_new;
    logic               r_failed, n_failed;
    t_status            r_fail_kind, n_fail_kind;
    logic               r_out_valid, n_out_valid;
    logic [COUNT_W-1:0] r_out_count, n_out_count;
    t_status            r_out_status, n_out_status;

    // memory ports
    logic               w_link_wr_en, w_link_rd_en;
    logic [NODE_W-1:0]  w_link_wr_addr;
    t_row               w_link_wr_data;
    logic [ROW_W-1:0]   w_link_rd_data;
    logic               w_cnt_wr_en, w_cnt_rd_en;
    logic [NODE_W-1:0]  w_cnt_wr_addr, w_cnt_rd_addr;
    logic [COUNT_W-1:0] w_cnt_wr_data, w_cnt_rd_data;

    // lookup decode
    t_row               w_row;
    logic [NODE_W-1:0]  w_slot;
    logic               w_alloc;
    logic               w_miss;
    logic [NODE_W-1:0]  w_nxt;
    t_status            w_miss_kind;
    logic               w_pop;
    t_status            w_held_kind;

    twc_ram #(.WIDTH(ROW_W), .DEPTH(NODE_COUNT)) u_link_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_link_wr_en),
        .i_wr_addr (w_link_wr_addr),
        .i_wr_data (w_link_wr_data),
        .i_rd_en   (w_link_rd_en),
        .i_rd_addr (r_cur),
        .o_rd_data (w_link_rd_data)
    );

    twc_ram #(.WIDTH(COUNT_W), .DEPTH(NODE_COUNT)) u_count_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_cnt_wr_en),
        .i_wr_addr (w_cnt_wr_addr),
        .i_wr_data (w_cnt_wr_data),
        .i_rd_en   (w_cnt_rd_en),
        .i_rd_addr (w_cnt_rd_addr),
        .o_rd_data (w_cnt_rd_data)
    );

    // take a letter only when idle and the result register is free or draining
    assign w_pop = (r_state == BK_IDLE) && i_head.valid
                   && (!r_out_valid || o_result.ready);
    assign o_pop = w_pop;

    // child link lookup for the current letter
    assign w_row       = t_row'(w_link_rd_data);
    assign w_slot      = w_row[r_op.code];
    assign w_alloc     = (w_slot == NODE_ROOT) && (r_op.kind == CMD_INSERT)
                         && (r_nodes_used != NODE_MAX);
    assign w_miss      = (w_slot == NODE_ROOT) && !w_alloc;
    assign w_miss_kind = (r_op.kind == CMD_QUERY) ? ST_NOT_FOUND : ST_POOL_FULL;
    assign w_nxt       = w_alloc ? (r_nodes_used + 1'b1) : w_slot;
    assign w_held_kind = r_failed ? r_fail_kind : ST_BAD_LETTER;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_INIT: begin
                n_state = BK_IDLE;
            end
            BK_IDLE: begin
                if (w_pop && (i_head.op.kind != CMD_CLEAR)
                        && !r_failed && !i_head.op.bad) begin
                    n_state = BK_STEP;
                end
            end
            BK_STEP: begin
                if (w_alloc) begin
                    n_state = BK_ALLOC;
                end else if (!w_miss && r_op.last) begin
                    n_state = BK_CNT;
                end else begin
                    n_state = BK_IDLE;
                end
            end
            BK_ALLOC: begin
                n_state = BK_IDLE;
            end
            BK_CNT: begin
                n_state = BK_IDLE;
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_op           = r_op;
        n_cur          = r_cur;
        n_nodes_used   = r_nodes_used;
        n_new          = r_new;
        n_failed       = r_failed;
        n_fail_kind    = r_fail_kind;
        n_out_valid    = r_out_valid && !o_result.ready;
        n_out_count    = r_out_count;
        n_out_status   = r_out_status;
        w_link_wr_en   = 1'b0;
        w_link_wr_addr = r_cur;
        w_link_wr_data = w_row;
        w_link_rd_en   = 1'b0;
        w_cnt_wr_en    = 1'b0;
        w_cnt_wr_addr  = r_cur;
        w_cnt_wr_data  = '0;
        w_cnt_rd_en    = 1'b0;
        w_cnt_rd_addr  = w_nxt;
        case (r_state)
            BK_INIT: begin
                // empty root after reset
                w_link_wr_en   = 1'b1;
                w_link_wr_addr = NODE_ROOT;
                w_link_wr_data = '0;
                w_cnt_wr_en    = 1'b1;
                w_cnt_wr_addr  = NODE_ROOT;
            end
            BK_IDLE: begin
                if (w_pop) begin
                    n_op = i_head.op;
                    if (i_head.op.kind == CMD_CLEAR) begin
                        w_link_wr_en   = 1'b1;
                        w_link_wr_addr = NODE_ROOT;
                        w_link_wr_data = '0;
                        w_cnt_wr_en    = 1'b1;
                        w_cnt_wr_addr  = NODE_ROOT;
                        n_nodes_used   = NODE_ROOT;
                        n_cur          = NODE_ROOT;
                        n_failed       = 1'b0;
                        n_fail_kind    = ST_OK;
                        n_out_valid    = 1'b1;
                        n_out_count    = '0;
                        n_out_status   = ST_OK;
                    end else if (r_failed || i_head.op.bad) begin
                        if (i_head.op.last) begin
                            n_out_valid  = 1'b1;
                            n_out_count  = '0;
                            n_out_status = w_held_kind;
                            n_cur        = NODE_ROOT;
                            n_failed     = 1'b0;
                            n_fail_kind  = ST_OK;
                        end else begin
                            n_failed     = 1'b1;
                            n_fail_kind  = w_held_kind;
                        end
                    end else begin
                        w_link_rd_en = 1'b1;
                    end
                end
            end
            BK_STEP: begin
                if (w_alloc) begin
                    // link the new child into the current node
                    w_link_wr_en          = 1'b1;
                    w_link_wr_data[r_op.code] = w_nxt;
                    n_nodes_used          = w_nxt;
                    n_new                 = w_nxt;
                end
                if (w_miss) begin
                    if (r_op.last) begin
                        n_out_valid  = 1'b1;
                        n_out_count  = '0;
                        n_out_status = w_miss_kind;
                        n_cur        = NODE_ROOT;
                        n_failed     = 1'b0;
                        n_fail_kind  = ST_OK;
                    end else begin
                        n_failed     = 1'b1;
                        n_fail_kind  = w_miss_kind;
                    end
                end else begin
                    n_cur       = w_nxt;
                    w_cnt_rd_en = r_op.last && !w_alloc;
                end
            end
            BK_ALLOC: begin
                // a fresh node starts with no children
                w_link_wr_en   = 1'b1;
                w_link_wr_addr = r_new;
                w_link_wr_data = '0;
                w_cnt_wr_en    = 1'b1;
                w_cnt_wr_addr  = r_new;
                w_cnt_wr_data  = r_op.last ? COUNT_ONE : '0;
                if (r_op.last) begin
                    n_out_valid  = 1'b1;
                    n_out_count  = COUNT_ONE;
                    n_out_status = ST_OK;
                    n_cur        = NODE_ROOT;
                end
            end
            BK_CNT: begin
                n_out_valid  = 1'b1;
                n_out_status = ST_OK;
                n_out_count  = w_cnt_rd_data;
                if (r_op.kind == CMD_INSERT) begin
                    w_cnt_wr_en = 1'b1;
                    if (w_cnt_rd_data != COUNT_MAX) begin
                        n_out_count = w_cnt_rd_data + 1'b1;
                    end
                    w_cnt_wr_data = n_out_count;
                end
                n_cur = NODE_ROOT;
            end
            default: begin
                n_cur = NODE_ROOT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= BK_INIT;
            r_cur        <= NODE_ROOT;
            r_nodes_used <= NODE_ROOT;
            r_failed     <= 1'b0;
            r_fail_kind  <= ST_OK;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cur        <= n_cur;
            r_nodes_used <= n_nodes_used;
            r_failed     <= n_failed;
            r_fail_kind  <= n_fail_kind;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_new        <= n_new;
        r_out_count  <= n_out_count;
        r_out_status <= n_out_status;
    end

    assign o_result.valid  = r_out_valid;
    assign o_result.count  = r_out_count;
    assign o_result.status = r_out_status;

    `TWC_NEVER(a_pop_busy_out, w_pop && r_out_valid && !o_result.ready, "word taken while result pending")
    `TWC_CHECK(a_alloc_then_clear,
        ((r_state == BK_STEP) && w_alloc) |=> (r_state == BK_ALLOC),
        "allocation not followed by row clear")
    `TWC_NEVER(a_alloc_root, (r_state == BK_ALLOC) && (r_new == NODE_ROOT),
        "root allocated as a child")

endmodule

### hdl/trie_word_counter.sv
// Per letter, the walker reads the link row in the idle state, then follows it in
// the step state; a new node adds the alloc state and a last letter on an existing
// node adds a count read in the count state. Clear, bad letters and letters of a failed word are handled in idle alone.
// The queue registers each letter; the walker takes the next one only once back in idle.
// Reset: synchronous, active low; the init state after reset empties the root node.
// ----------------------------------------------------------------------------
// trie_word_counter
// Counting trie over 52 letters: a front queue of classified letters feeds a
// walker that follows, allocates and counts nodes in a pool held in RAM.
// ----------------------------------------------------------------------------
module trie_word_counter import twc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    twc_in_if.sink     i_word,
    twc_out_if.source  o_result
);

    t_q_head w_head;
    logic    w_pop;

    // letter intake and queue
    twc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_word  (i_word),
        .i_pop   (w_pop),
        .o_head  (w_head)
    );

    // trie walker
    twc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .o_pop    (w_pop),
        .o_result (o_result)
    );

endmodule
